>>> rtl/core/tgap_pkg.sv
// Shared types and constants for the uncompressed TGA stream parser.
package tgap_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PIXELS,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_PIXEL  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_ID_LEN = 3'd1,
        ERR_CMAP   = 3'd2,
        ERR_TYPE   = 3'd3,
        ERR_ORIGIN = 3'd4,
        ERR_SIZE   = 3'd5,
        ERR_DEPTH  = 3'd6
    } err_t;

    localparam logic [4:0] HP_ID_LEN   = 5'd0;
    localparam logic [4:0] HP_CMAP     = 5'd1;
    localparam logic [4:0] HP_TYPE     = 5'd2;
    localparam logic [4:0] HP_ORG_X_LO = 5'd8;
    localparam logic [4:0] HP_ORG_X_HI = 5'd9;
    localparam logic [4:0] HP_ORG_Y_LO = 5'd10;
    localparam logic [4:0] HP_ORG_Y_HI = 5'd11;
    localparam logic [4:0] HP_WIDTH_LO = 5'd12;
    localparam logic [4:0] HP_WIDTH_HI = 5'd13;
    localparam logic [4:0] HP_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HP_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HP_DEPTH    = 5'd16;
    localparam logic [4:0] HP_LAST     = 5'd17;

    localparam logic [7:0] TYPE_TRUECOLOUR = 8'd2;
    localparam logic [7:0] TYPE_GREY       = 8'd3;
    localparam logic [7:0] DEPTH_24        = 8'd24;
    localparam logic [7:0] DEPTH_32        = 8'd32;

    localparam logic [1:0] CH_BLUE  = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd2;
    localparam logic [1:0] CH_ALPHA = 2'd3;

    localparam int TDATA_W = 104;

    typedef struct packed {
        kind_t       kind;
        err_t        err;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        has_alpha;
        logic [15:0] column;
        logic [15:0] row;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last;
    } res_t;

endpackage

>>> rtl/core/tgap_front.sv
// Front end: takes byte transfers, tracks header and pixel state, builds results.
module tgap_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    input  logic                 start_req,
    output logic                 emit,
    output tgap_pkg::res_t       res
);

    tgap_pkg::phase_t phase_reg, phase_next;
    logic [4:0]  hpos_reg, hpos_next;
    logic [1:0]  chpos_reg, chpos_next;
    logic [15:0] idmap_reg, idmap_next;
    logic [7:0]  type_reg, type_next;
    logic        origin_reg, origin_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [7:0]  depth_reg, depth_next;
    logic [23:0] partial_reg, partial_next;
    logic [15:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;

    logic        alpha4;
    logic [1:0]  lastch;
    logic        row_end;
    logic        lastpix;
    tgap_pkg::err_t err;

    always_comb
    begin
        phase_next   = phase_reg;
        hpos_next    = hpos_reg;
        chpos_next   = chpos_reg;
        idmap_next   = idmap_reg;
        type_next    = type_reg;
        origin_next  = origin_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        depth_next   = depth_reg;
        partial_next = partial_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        emit         = 1'b0;
        res          = '0;
        err          = tgap_pkg::ERR_NONE;
        alpha4       = 1'b0;
        lastch       = tgap_pkg::CH_RED;
        row_end      = 1'b0;
        lastpix      = 1'b0;

        if (start_req)
        begin
            phase_next   = tgap_pkg::PH_HEADER;
            hpos_next    = '0;
            chpos_next   = '0;
            idmap_next   = '0;
            type_next    = '0;
            origin_next  = 1'b0;
            width_next   = '0;
            height_next  = '0;
            depth_next   = '0;
            partial_next = '0;
            col_next     = '0;
            row_next     = '0;
        end

        unique case (phase_next)
            tgap_pkg::PH_HEADER:
            begin
                unique case (hpos_next)
                    tgap_pkg::HP_ID_LEN:    idmap_next[7:0]   = data_byte;
                    tgap_pkg::HP_CMAP:      idmap_next[15:8]  = data_byte;
                    tgap_pkg::HP_TYPE:      type_next         = data_byte;
                    tgap_pkg::HP_ORG_X_LO,
                    tgap_pkg::HP_ORG_X_HI,
                    tgap_pkg::HP_ORG_Y_LO,
                    tgap_pkg::HP_ORG_Y_HI:  origin_next = origin_next | (data_byte != 8'd0);
                    tgap_pkg::HP_WIDTH_LO:  width_next[7:0]   = data_byte;
                    tgap_pkg::HP_WIDTH_HI:  width_next[15:8]  = data_byte;
                    tgap_pkg::HP_HEIGHT_LO: height_next[7:0]  = data_byte;
                    tgap_pkg::HP_HEIGHT_HI: height_next[15:8] = data_byte;
                    tgap_pkg::HP_DEPTH:     depth_next        = data_byte;
                    default:                ;
                endcase

                if (hpos_next != tgap_pkg::HP_LAST)
                begin
                    hpos_next = hpos_next + 5'd1;
                end
                else
                begin
                    priority if (idmap_next[7:0] != 8'd0)
                        err = tgap_pkg::ERR_ID_LEN;
                    else if (idmap_next[15:8] != 8'd0)
                        err = tgap_pkg::ERR_CMAP;
                    else if (type_next != tgap_pkg::TYPE_TRUECOLOUR &&
                             type_next != tgap_pkg::TYPE_GREY)
                        err = tgap_pkg::ERR_TYPE;
                    else if (origin_next)
                        err = tgap_pkg::ERR_ORIGIN;
                    else if (width_next == 16'd0 || height_next == 16'd0)
                        err = tgap_pkg::ERR_SIZE;
                    else if (depth_next != tgap_pkg::DEPTH_24 &&
                             depth_next != tgap_pkg::DEPTH_32)
                        err = tgap_pkg::ERR_DEPTH;
                    else
                        err = tgap_pkg::ERR_NONE;

                    emit             = 1'b1;
                    res.image_width  = width_next;
                    res.image_height = height_next;
                    if (err != tgap_pkg::ERR_NONE)
                    begin
                        res.kind   = tgap_pkg::KIND_REJECT;
                        res.err    = err;
                        phase_next = tgap_pkg::PH_DONE;
                    end
                    else
                    begin
                        res.kind      = tgap_pkg::KIND_ACCEPT;
                        res.has_alpha = (depth_next == tgap_pkg::DEPTH_32);
                        phase_next    = tgap_pkg::PH_PIXELS;
                        chpos_next    = '0;
                        col_next      = '0;
                        row_next      = '0;
                    end
                end
            end

            tgap_pkg::PH_PIXELS:
            begin
                alpha4 = (depth_next == tgap_pkg::DEPTH_32);
                lastch = alpha4 ? tgap_pkg::CH_ALPHA : tgap_pkg::CH_RED;
                unique case (chpos_next)
                    tgap_pkg::CH_BLUE:  partial_next[7:0]   = data_byte;
                    tgap_pkg::CH_GREEN: partial_next[15:8]  = data_byte;
                    tgap_pkg::CH_RED:   partial_next[23:16] = data_byte;
                    tgap_pkg::CH_ALPHA: ;
                endcase

                if (chpos_next < lastch)
                begin
                    chpos_next = chpos_next + 2'd1;
                end
                else
                begin
                    chpos_next = '0;
                    row_end    = (col_next == width_next - 16'd1);
                    lastpix    = row_end && (row_next == height_next - 16'd1);

                    emit             = 1'b1;
                    res.kind         = tgap_pkg::KIND_PIXEL;
                    res.image_width  = width_next;
                    res.image_height = height_next;
                    res.has_alpha    = alpha4;
                    res.column       = col_next;
                    res.row          = row_next;
                    res.red          = partial_next[23:16];
                    res.green        = partial_next[15:8];
                    res.blue         = partial_next[7:0];
                    res.alpha        = alpha4 ? data_byte : 8'd0;
                    res.last         = lastpix;

                    priority if (lastpix)
                        phase_next = tgap_pkg::PH_DONE;
                    else if (row_end)
                    begin
                        col_next = '0;
                        row_next = row_next + 16'd1;
                    end
                    else
                        col_next = col_next + 16'd1;
                end
            end

            tgap_pkg::PH_IDLE,
            tgap_pkg::PH_DONE: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tgap_pkg::PH_IDLE;
            hpos_reg  <= '0;
            chpos_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            hpos_reg  <= hpos_next;
            chpos_reg <= chpos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idmap_reg   <= idmap_next;
            type_reg    <= type_next;
            origin_reg  <= origin_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            depth_reg   <= depth_next;
            partial_reg <= partial_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

endmodule

>>> rtl/core/tgap_fifo.sv
// Short result queue between the front end and the output stage.
module tgap_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tgap_pkg::res_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output tgap_pkg::res_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tgap_pkg::res_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count did not advance on push");
`endif

endmodule

>>> rtl/core/tgap_back.sv
// Back end: output register stage that formats queued results into master transfers.
module tgap_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  tgap_pkg::res_t               q_data,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [tgap_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]                   m_tuser,
    output logic                         m_tlast
);

    tgap_pkg::res_t out_reg;
    logic           valid_reg;
    logic           load;

    assign load  = !valid_reg || m_tready;
    assign q_pop = q_valid && load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            out_reg <= q_data;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {4'd0,
                       out_reg.alpha,
                       out_reg.blue,
                       out_reg.green,
                       out_reg.red,
                       out_reg.row,
                       out_reg.column,
                       out_reg.has_alpha,
                       out_reg.image_height,
                       out_reg.image_width,
                       out_reg.err};

endmodule

>>> rtl/core/tga_uncompressed_stream_parser_top.sv
// A result passes through the result queue and then the output register before it leaves on m_tdata.
// Throughput: one byte transfer per cycle; the front end stalls only when the result queue
// (FIFO_DEPTH entries) is full, which happens only while m_tready is held low.
// A header result follows the 18th header byte; a pixel follows its 3rd or 4th channel byte.
// Reset: rst_n is asynchronous and active low; it empties the queue and output register
// and returns the parser to waiting for a start byte.
module tga_uncompressed_stream_parser_top
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // data_byte[7:0]
    input  logic                         s_tuser,   // start_req
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // error_code[2:0], image_width[18:3], image_height[34:19], has_alpha[35],
    // column[51:36], row[67:52], red[75:68], green[83:76], blue[91:84],
    // alpha[99:92], zero[103:100]
    output logic [tgap_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]                   m_tuser,   // kind[1:0]
    output logic                         m_tlast
);

    logic           accept;
    logic           emit;
    tgap_pkg::res_t front_res;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    tgap_pkg::res_t q_data;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    tgap_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (s_tdata),
        .start_req (s_tuser),
        .emit      (emit),
        .res       (front_res)
    );

    tgap_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && emit),
        .push_data (front_res),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    tgap_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTH
    a_last_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> m_tuser == tgap_pkg::KIND_PIXEL)
        else $error("last flag on a header result");

    a_reject_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == tgap_pkg::KIND_REJECT) |-> m_tdata[2:0] != tgap_pkg::ERR_NONE)
        else $error("rejected header without error code");

    a_code_only_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != tgap_pkg::KIND_REJECT) |-> m_tdata[2:0] == tgap_pkg::ERR_NONE)
        else $error("error code on a non-reject result");
`endif

endmodule

>>> dv/tga_uncompressed_stream_parser_tb.sv
// Self-checking testbench for the TGA stream parser: random TGA files, stalls, field checks.
class tga_decode_tracker;
    tgap_pkg::phase_t stage;
    logic [4:0]       hdr_idx;
    logic [15:0]      id_map;
    logic [7:0]       img_type;
    bit               org_nz;
    logic [15:0]      wid;
    logic [15:0]      hgt;
    logic [7:0]       depth;
    logic [1:0]       chan_idx;
    logic [23:0]      chans;
    logic [15:0]      col;
    logic [15:0]      rw;
    tgap_pkg::res_t   expected_q[$];
    int unsigned      mismatches;

    function new();
        stage      = tgap_pkg::PH_IDLE;
        mismatches = 0;
        clear_file();
    endfunction

    function void clear_file();
        hdr_idx  = '0;
        id_map   = '0;
        img_type = '0;
        org_nz   = 1'b0;
        wid      = '0;
        hgt      = '0;
        depth    = '0;
        chan_idx = '0;
        chans    = '0;
        col      = '0;
        rw       = '0;
    endfunction

    function tgap_pkg::err_t header_error();
        if (id_map[7:0] != 8'd0) return tgap_pkg::ERR_ID_LEN;
        if (id_map[15:8] != 8'd0) return tgap_pkg::ERR_CMAP;
        if (img_type != tgap_pkg::TYPE_TRUECOLOUR && img_type != tgap_pkg::TYPE_GREY)
            return tgap_pkg::ERR_TYPE;
        if (org_nz) return tgap_pkg::ERR_ORIGIN;
        if (wid == 16'd0 || hgt == 16'd0) return tgap_pkg::ERR_SIZE;
        if (depth != tgap_pkg::DEPTH_24 && depth != tgap_pkg::DEPTH_32)
            return tgap_pkg::ERR_DEPTH;
        return tgap_pkg::ERR_NONE;
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    // note an accepted byte; returns 1 when the parser does not ignore it
    function bit take_byte(input logic [7:0] b, input logic st);
        tgap_pkg::res_t r;
        tgap_pkg::err_t e;
        bit             used;
        bit             a4;
        logic [1:0]     lastch;
        if (st)
        begin
            stage = tgap_pkg::PH_HEADER;
            clear_file();
        end
        used = (stage == tgap_pkg::PH_HEADER || stage == tgap_pkg::PH_PIXELS);
        r    = '0;
        if (stage == tgap_pkg::PH_HEADER)
        begin
            case (hdr_idx)
                tgap_pkg::HP_ID_LEN:    id_map[7:0]  = b;
                tgap_pkg::HP_CMAP:      id_map[15:8] = b;
                tgap_pkg::HP_TYPE:      img_type     = b;
                tgap_pkg::HP_ORG_X_LO, tgap_pkg::HP_ORG_X_HI,
                tgap_pkg::HP_ORG_Y_LO, tgap_pkg::HP_ORG_Y_HI:
                    if (b != 8'd0) org_nz = 1'b1;
                tgap_pkg::HP_WIDTH_LO:  wid[7:0]     = b;
                tgap_pkg::HP_WIDTH_HI:  wid[15:8]    = b;
                tgap_pkg::HP_HEIGHT_LO: hgt[7:0]     = b;
                tgap_pkg::HP_HEIGHT_HI: hgt[15:8]    = b;
                tgap_pkg::HP_DEPTH:     depth        = b;
                default: ;
            endcase
            if (hdr_idx != tgap_pkg::HP_LAST)
                hdr_idx = hdr_idx + 5'd1;
            else
            begin
                e = header_error();
                r.image_width  = wid;
                r.image_height = hgt;
                if (e != tgap_pkg::ERR_NONE)
                begin
                    r.kind = tgap_pkg::KIND_REJECT;
                    r.err  = e;
                    stage  = tgap_pkg::PH_DONE;
                end
                else
                begin
                    r.kind      = tgap_pkg::KIND_ACCEPT;
                    r.err       = tgap_pkg::ERR_NONE;
                    r.has_alpha = (depth == tgap_pkg::DEPTH_32);
                    stage       = tgap_pkg::PH_PIXELS;
                    chan_idx    = '0;
                    col         = '0;
                    rw          = '0;
                end
                expected_q.push_back(r);
            end
        end
        else if (stage == tgap_pkg::PH_PIXELS)
        begin
            a4     = (depth == tgap_pkg::DEPTH_32);
            lastch = a4 ? tgap_pkg::CH_ALPHA : tgap_pkg::CH_RED;
            if (chan_idx != tgap_pkg::CH_ALPHA)
                chans[8*chan_idx +: 8] = b;
            if (chan_idx < lastch)
                chan_idx = chan_idx + 2'd1;
            else
            begin
                chan_idx       = tgap_pkg::CH_BLUE;
                r.kind         = tgap_pkg::KIND_PIXEL;
                r.err          = tgap_pkg::ERR_NONE;
                r.image_width  = wid;
                r.image_height = hgt;
                r.has_alpha    = a4;
                r.column       = col;
                r.row          = rw;
                r.red          = chans[23:16];
                r.green        = chans[15:8];
                r.blue         = chans[7:0];
                r.alpha        = a4 ? b : 8'd0;
                r.last         = (col == wid - 16'd1) && (rw == hgt - 16'd1);
                if (r.last)
                    stage = tgap_pkg::PH_DONE;
                else if (col == wid - 16'd1)
                begin
                    col = '0;
                    rw  = rw + 16'd1;
                end
                else
                    col = col + 16'd1;
                expected_q.push_back(r);
            end
        end
        return used;
    endfunction

    function void check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function void check_result(input logic [tgap_pkg::TDATA_W-1:0] td,
                               input logic [1:0] tu, input logic tl);
        tgap_pkg::res_t want;
        if (expected_q.size() == 0)
        begin
            $error("result with nothing expected: kind %0d", tu);
            mismatches++;
            return;
        end
        want = expected_q.pop_front();
        check_field("kind", 16'(want.kind), 16'(tu));
        check_field("error_code", 16'(want.err), 16'(td[2:0]));
        check_field("image_width", want.image_width, td[18:3]);
        check_field("image_height", want.image_height, td[34:19]);
        check_field("has_alpha", 16'(want.has_alpha), 16'(td[35]));
        check_field("column", want.column, td[51:36]);
        check_field("row", want.row, td[67:52]);
        check_field("red", 16'(want.red), 16'(td[75:68]));
        check_field("green", 16'(want.green), 16'(td[83:76]));
        check_field("blue", 16'(want.blue), 16'(td[91:84]));
        check_field("alpha", 16'(want.alpha), 16'(td[99:92]));
        check_field("last", 16'(want.last), 16'(tl));
    endfunction
endclass

module testbench;

    localparam int unsigned RANDOM_ITEMS   = 1200;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [7:0]                   s_tdata;
    logic                         s_tuser;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [tgap_pkg::TDATA_W-1:0] m_tdata;
    logic [1:0]                   m_tuser;
    logic                         m_tlast;

    tga_decode_tracker tracker = new();
    bit                calm  = 1'b0;
    bit                gappy = 1'b1;
    int unsigned       consumed = 0;
    int unsigned       idle_cycles = 0;

    tga_uncompressed_stream_parser_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic send_byte(input logic [7:0] b, input logic st);
        if (!calm && gappy && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        do @(posedge clk); while (!s_tready);
        if (tracker.take_byte(b, st))
            consumed++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (tracker.pending() != 0);
    endtask

    task automatic stream_file();
        logic [7:0]     hdr [18];
        tgap_pkg::err_t flaw;
        logic [15:0]    w;
        logic [15:0]    h;
        int unsigned    sel;
        int unsigned    n_hdr;
        int unsigned    n_body;
        int unsigned    pos;
        sel   = $urandom_range(0, 19);
        gappy = ($urandom_range(0, 3) != 0);
        flaw  = (sel >= 14 && sel <= 18) ? tgap_pkg::err_t'($urandom_range(1, 6))
                                         : tgap_pkg::ERR_NONE;
        for (int i = 0; i < 18; i++)
            hdr[i] = 8'($urandom_range(0, 255));
        w = 16'($urandom_range(1, 5));
        h = 16'($urandom_range(1, 4));
        if (sel == 12 || sel == 13)
        begin
            w = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535));
            h = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535));
        end

        if (flaw == tgap_pkg::ERR_ID_LEN)
            hdr[tgap_pkg::HP_ID_LEN] = 8'($urandom_range(1, 255));
        else
            hdr[tgap_pkg::HP_ID_LEN] = 8'd0;

        if (flaw == tgap_pkg::ERR_CMAP)
            hdr[tgap_pkg::HP_CMAP] = 8'($urandom_range(1, 255));
        else if (flaw == tgap_pkg::ERR_NONE || flaw > tgap_pkg::ERR_CMAP)
            hdr[tgap_pkg::HP_CMAP] = 8'd0;

        if (flaw == tgap_pkg::ERR_TYPE)
        begin
            while (hdr[tgap_pkg::HP_TYPE] == tgap_pkg::TYPE_TRUECOLOUR ||
                   hdr[tgap_pkg::HP_TYPE] == tgap_pkg::TYPE_GREY)
                hdr[tgap_pkg::HP_TYPE] = 8'($urandom_range(0, 255));
        end
        else if (flaw == tgap_pkg::ERR_NONE || flaw > tgap_pkg::ERR_TYPE)
            hdr[tgap_pkg::HP_TYPE] = $urandom_range(0, 1) ? tgap_pkg::TYPE_GREY
                                                          : tgap_pkg::TYPE_TRUECOLOUR;

        if (flaw == tgap_pkg::ERR_ORIGIN)
        begin
            pos      = tgap_pkg::HP_ORG_X_LO + $urandom_range(0, 3);
            hdr[pos] = 8'($urandom_range(1, 255));
        end
        else if (flaw == tgap_pkg::ERR_NONE || flaw > tgap_pkg::ERR_ORIGIN)
        begin
            for (int i = tgap_pkg::HP_ORG_X_LO; i <= tgap_pkg::HP_ORG_Y_HI; i++)
                hdr[i] = 8'd0;
        end

        if (flaw == tgap_pkg::ERR_SIZE)
        begin
            if ($urandom_range(0, 1))
                w = '0;
            else
                h = '0;
            if ($urandom_range(0, 3) == 0)
            begin
                w = '0;
                h = '0;
            end
        end
        if (flaw == tgap_pkg::ERR_NONE || flaw >= tgap_pkg::ERR_SIZE)
        begin
            hdr[tgap_pkg::HP_WIDTH_LO]  = w[7:0];
            hdr[tgap_pkg::HP_WIDTH_HI]  = w[15:8];
            hdr[tgap_pkg::HP_HEIGHT_LO] = h[7:0];
            hdr[tgap_pkg::HP_HEIGHT_HI] = h[15:8];
        end

        if (flaw == tgap_pkg::ERR_DEPTH)
        begin
            while (hdr[tgap_pkg::HP_DEPTH] == tgap_pkg::DEPTH_24 ||
                   hdr[tgap_pkg::HP_DEPTH] == tgap_pkg::DEPTH_32)
                hdr[tgap_pkg::HP_DEPTH] = 8'($urandom_range(0, 255));
        end
        else if (flaw == tgap_pkg::ERR_NONE || flaw > tgap_pkg::ERR_DEPTH)
            hdr[tgap_pkg::HP_DEPTH] = $urandom_range(0, 1) ? tgap_pkg::DEPTH_32
                                                           : tgap_pkg::DEPTH_24;

        n_hdr  = (sel == 19) ? $urandom_range(1, 17) : 18;
        n_body = 0;
        if (sel <= 11)
            n_body = w * h * ((hdr[tgap_pkg::HP_DEPTH] == tgap_pkg::DEPTH_32) ? 4 : 3);
        else if (sel <= 13)
            n_body = $urandom_range(0, 20);

        for (int i = 0; i < n_hdr; i++)
            send_byte(hdr[i], i == 0);
        for (int i = 0; i < n_body; i++)
        begin
            case ($urandom_range(0, 7))
                0:       send_byte(8'h00, 1'b0);
                1:       send_byte(8'hFF, 1'b0);
                default: send_byte(8'($urandom_range(0, 255)), 1'b0);
            endcase
        end
        if (sel != 19)
        begin
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            if (!calm && $urandom_range(0, 2) != 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tdata, m_tuser, m_tlast);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0]  seq [25];
        int unsigned file_idx;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tuser  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // drop two bytes before any start, then a 1x1 32-bit image and a trailing byte
        seq = '{8'hFF, 8'h00,
                8'h00, 8'h00, tgap_pkg::TYPE_TRUECOLOUR, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'hFF,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00,
                tgap_pkg::DEPTH_32, 8'h28,
                8'h00, 8'hFF, 8'h80, 8'h7F,
                8'hFF};
        for (int i = 0; i < 25; i++)
            send_byte(seq[i], i == 2);
        drain();

        consumed = 0;
        file_idx = 0;
        while (consumed < RANDOM_ITEMS)
        begin
            if (consumed > RANDOM_ITEMS * 17 / 20)
                calm = 1'b1;
            if (file_idx % 6 == 0)
                drain();
            stream_file();
            file_idx++;
        end
        drain();
        repeat (10) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
